// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the unpacker RTL
// Concurrent checks clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SUDCU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SUDCU_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/core/sudcu_pkg.sv -----
// ----------------------------------------------------------------------------
// SMS user data unpacker package
// Shared types and constants of the user data character unpacker.
// ----------------------------------------------------------------------------
package sudcu_pkg;

   localparam int unsigned MAX_USER_BYTES_DEF = 128;
   localparam int unsigned QUEUE_DEPTH        = 2;

   localparam int unsigned REQ_TDATA_W = 8;
   localparam int unsigned RSP_TDATA_W = 48;

   // Encodings with a character size of their own.
   localparam logic [4:0] ENC_IS91    = 5'd1;
   localparam logic [4:0] ENC_ASCII7  = 5'd2;
   localparam logic [4:0] ENC_IA5     = 5'd3;
   localparam logic [4:0] ENC_UNICODE = 5'd4;

   localparam logic [4:0] SIZE_IS91    = 5'd6;
   localparam logic [4:0] SIZE_SEVEN   = 5'd7;
   localparam logic [4:0] SIZE_UNICODE = 5'd16;
   localparam logic [4:0] SIZE_OCTET   = 5'd8;

   // A unicode count above this is taken as a byte count and halved.
   localparam logic [7:0] UNICODE_COUNT_LIMIT = 8'd70;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_CHAR   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // All results caused by one accepted byte (one or two).
   typedef struct packed {
      logic        two;
      kind_type    kind0;
      kind_type    kind1;
      logic [4:0]  encoding;
      logic [7:0]  message_type;
      logic [7:0]  char_count;
      logic [7:0]  index0;
      logic [7:0]  index1;
      logic [15:0] value0;
      logic [15:0] value1;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- rtl/core/sudcu_front.sv -----
// ----------------------------------------------------------------------------
// Unpacker front end
// Accepts bytes, extracts the header fields and characters, and queues the
// results that each byte causes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sudcu_front #(
   parameter int unsigned MAX_USER_BYTES = sudcu_pkg::MAX_USER_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 data_byte,
   input  logic                       last_byte,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  sudcu_pkg::queue_status_type q_status,
   output logic                       push,
   output sudcu_pkg::entry_type       push_entry
);
   import sudcu_pkg::*;

   typedef enum logic [2:0] {
      PH_ENC,
      PH_MTYPE,
      PH_COUNT,
      PH_CHARS,
      PH_IDLE
   } phase_type;

   // Fewer bits than the pending field needs are held between bytes, so the
   // eight new bits complete at most two fields.
   localparam int STEPS = 2;

   phase_type   phase_ff, phase_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  held_ff, held_in;
   logic [4:0]  enc_ff, enc_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  sent_ff, sent_in;
   logic [4:0]  size_ff, size_in;
   logic [1:0]  nres;
   logic        accept;

   function automatic logic [15:0] take_field(logic [23:0] b, logic [4:0] h, logic [4:0] n);
      logic [23:0] sh;
      logic [23:0] m;
      sh = b >> (h - n);
      m  = ~(24'hFFFFFF << n);
      return 16'(sh & m);
   endfunction

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      logic [4:0]  need;
      logic [15:0] fld;
      logic [12:0] prod;
      kind_type    kind_v [2];
      logic [7:0]  idx_v [2];
      logic [15:0] val_v [2];

      phase_in = phase_ff;
      buf_in   = {buf_ff[15:0], data_byte};
      held_in  = held_ff + 5'd8;
      enc_in   = enc_ff;
      mtype_in = mtype_ff;
      count_in = count_ff;
      sent_in  = sent_ff;
      size_in  = size_ff;
      nres     = 2'd0;
      kind_v   = '{KIND_HEADER, KIND_HEADER};
      idx_v    = '{8'd0, 8'd0};
      val_v    = '{16'd0, 16'd0};
      need     = SIZE_OCTET;
      fld      = '0;
      prod     = '0;

      for (int s = 0; s < STEPS; s++) begin
         unique case (phase_in)
            PH_ENC:   need = 5'd5;
            PH_CHARS: need = size_in;
            default:  need = SIZE_OCTET;
         endcase
         if (phase_in != PH_IDLE && held_in >= need) begin
            fld     = take_field(buf_in, held_in, need);
            held_in = held_in - need;
            buf_in  = buf_in & ~(24'hFFFFFF << held_in);
            unique case (phase_in)
               PH_ENC: begin
                  enc_in   = fld[4:0];
                  mtype_in = 8'd0;
                  unique case (fld[4:0])
                     ENC_IS91:            size_in = SIZE_IS91;
                     ENC_ASCII7, ENC_IA5: size_in = SIZE_SEVEN;
                     ENC_UNICODE:         size_in = SIZE_UNICODE;
                     default:             size_in = SIZE_OCTET;
                  endcase
                  phase_in = (fld[4:0] == ENC_IS91) ? PH_MTYPE : PH_COUNT;
               end
               PH_MTYPE: begin
                  mtype_in = fld[7:0];
                  phase_in = PH_COUNT;
               end
               PH_COUNT: begin
                  count_in = fld[7:0];
                  if (enc_in == ENC_UNICODE && count_in > UNICODE_COUNT_LIMIT) begin
                     count_in = count_in >> 1;
                  end
                  sent_in = 8'd0;
                  if (nres < 2'd2) begin
                     kind_v[nres[0]] = KIND_HEADER;
                     idx_v[nres[0]]  = 8'd0;
                     val_v[nres[0]]  = 16'd0;
                     nres            = nres + 2'd1;
                  end
                  prod = 13'(count_in) * 13'(size_in);
                  if (32'(prod >> 3) > 32'(MAX_USER_BYTES)) begin
                     if (nres < 2'd2) begin
                        kind_v[nres[0]] = KIND_ERROR;
                        idx_v[nres[0]]  = 8'd0;
                        val_v[nres[0]]  = 16'd0;
                        nres            = nres + 2'd1;
                     end
                     phase_in = PH_IDLE;
                  end else if (count_in == 8'd0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_CHARS;
                  end
               end
               PH_CHARS: begin
                  if (nres < 2'd2) begin
                     kind_v[nres[0]] = KIND_CHAR;
                     idx_v[nres[0]]  = sent_in;
                     val_v[nres[0]]  = fld;
                     nres            = nres + 2'd1;
                  end
                  sent_in = sent_in + 8'd1;
                  if (sent_in >= count_in) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // Once a message is done or failed, padding bits are dropped.
      if (phase_in == PH_IDLE) begin
         buf_in  = 24'd0;
         held_in = 5'd0;
      end

      // A header may share a byte with an error or a character, but the
      // encoding, message type and count stay the same for both results.
      push_entry.two          = (nres == 2'd2);
      push_entry.kind0        = kind_v[0];
      push_entry.kind1        = kind_v[1];
      push_entry.encoding     = enc_in;
      push_entry.message_type = mtype_in;
      push_entry.char_count   = count_in;
      push_entry.index0       = idx_v[0];
      push_entry.index1       = idx_v[1];
      push_entry.value0       = val_v[0];
      push_entry.value1       = val_v[1];
   end

   assign push = accept && (nres != 2'd0);

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         phase_ff <= PH_ENC;
         buf_ff   <= 24'd0;
         held_ff  <= 5'd0;
         enc_ff   <= 5'd0;
         mtype_ff <= 8'd0;
         count_ff <= 8'd0;
         sent_ff  <= 8'd0;
         size_ff  <= SIZE_OCTET;
      end else if (accept) begin
         phase_ff <= phase_in;
         buf_ff   <= buf_in;
         held_ff  <= held_in;
         enc_ff   <= enc_in;
         mtype_ff <= mtype_in;
         count_ff <= count_in;
         sent_ff  <= sent_in;
         size_ff  <= size_in;
      end
   end

   `SUDCU_ASSERT(a_idle_empty, clock, reset, phase_ff == PH_IDLE |-> held_ff == 5'd0, "idle with bits held")
   `SUDCU_ASSERT(a_held_range, clock, reset, held_ff < 5'd16, "bit buffer overfilled")

endmodule

// ----- rtl/core/sudcu_queue.sv -----
// ----------------------------------------------------------------------------
// Unpacker result queue
// Short register queue of per-byte result entries between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sudcu_queue #(
   parameter int unsigned DEPTH = sudcu_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sudcu_pkg::entry_type        push_entry,
   input  logic                        pop,
   output sudcu_pkg::entry_type        head,
   output sudcu_pkg::queue_status_type status
);
   import sudcu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign status.empty = (count_ff == CNT_W'(0));
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign head         = slot_ff[rd_ptr_ff];
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SUDCU_NEVER(a_no_overflow, clock, reset, push && status.full && !do_pop, "push into full queue")

endmodule

// ----- rtl/core/sudcu_back.sv -----
// ----------------------------------------------------------------------------
// Unpacker back end
// Takes queued entries apart into single results and holds each in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sudcu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sudcu_pkg::entry_type        head,
   input  sudcu_pkg::queue_status_type q_status,
   output logic                        pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output sudcu_pkg::kind_type         out_kind,
   output logic [4:0]                  out_encoding,
   output logic [7:0]                  out_message_type,
   output logic [7:0]                  out_char_count,
   output logic [7:0]                  out_char_index,
   output logic [15:0]                 out_char_value,
   output logic                        out_last
);
   import sudcu_pkg::*;

   logic        valid_ff;
   logic        second_ff;
   kind_type    kind_ff;
   logic [4:0]  enc_ff;
   logic [7:0]  mtype_ff;
   logic [7:0]  count_ff;
   logic [7:0]  index_ff;
   logic [15:0] value_ff;
   logic        last_ff;
   logic        load;
   logic        final_sel;

   assign load      = !valid_ff || out_ready;
   // The second result, or a lone first one, closes the entry.
   assign final_sel = second_ff || !head.two;
   assign pop       = load && !q_status.empty && final_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= !q_status.empty;
         if (!q_status.empty) begin
            second_ff <= !final_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && !q_status.empty) begin
         kind_ff  <= second_ff ? head.kind1 : head.kind0;
         enc_ff   <= head.encoding;
         mtype_ff <= head.message_type;
         count_ff <= head.char_count;
         index_ff <= second_ff ? head.index1 : head.index0;
         value_ff <= second_ff ? head.value1 : head.value0;
         last_ff  <= final_sel;
      end
   end

   assign out_valid        = valid_ff;
   assign out_kind         = kind_ff;
   assign out_encoding     = enc_ff;
   assign out_message_type = mtype_ff;
   assign out_char_count   = count_ff;
   assign out_char_index   = index_ff;
   assign out_char_value   = value_ff;
   assign out_last         = last_ff;

   `SUDCU_ASSERT(a_second_has_head, clock, reset, second_ff |-> !q_status.empty, "split entry lost")

endmodule

// ----- rtl/core/sms_user_data_char_unpacker.sv -----
// ----------------------------------------------------------------------------
// SMS user data character unpacker
// Reads encoding, message type and count from user data bytes and unpacks
// the characters, one result item per header, character or length error.
//
//   channel   direction   tdata                       tuser   tlast
//   req_*     in          data_byte                   -       last_byte
//   rsp_*     out         enc/mtype/count/idx/value   kind    last
//
// One byte is taken per cycle while the queue is not full; the two-entry queue
// absorbs bytes that cause two results. A result is registered in the queue
// and then in the output register before it can be taken.
// Synchronous reset empties the queue and output and expects an encoding.
// req_tready drops only while the queue is full; rsp_tready stalls the
// output register and, through it, the queue pop.
// ----------------------------------------------------------------------------
module sms_user_data_char_unpacker #(
   parameter int unsigned MAX_USER_BYTES = sudcu_pkg::MAX_USER_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // data_byte [7:0]
   input  logic [sudcu_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // encoding [4:0], message_type [12:5], char_count [20:13],
   // char_index [28:21], char_value [44:29], zero [47:45]
   output logic [sudcu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // kind [1:0]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import sudcu_pkg::*;

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head;
   logic             push;
   logic             pop;
   kind_type         out_kind;
   logic [4:0]       out_encoding;
   logic [7:0]       out_message_type;
   logic [7:0]       out_char_count;
   logic [7:0]       out_char_index;
   logic [15:0]      out_char_value;

   sudcu_front #(
      .MAX_USER_BYTES (MAX_USER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   sudcu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   sudcu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_kind         (out_kind),
      .out_encoding     (out_encoding),
      .out_message_type (out_message_type),
      .out_char_count   (out_char_count),
      .out_char_index   (out_char_index),
      .out_char_value   (out_char_value),
      .out_last         (rsp_tlast)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {3'b000, out_char_value, out_char_index, out_char_count,
                       out_message_type, out_encoding};

endmodule
